// ----- hw/rtl/ialu_pkg.sv -----
// ----------------------------------------------------------------------------
// ialu_pkg
// Shared types and constants for the 64-bit integer ALU.
// ----------------------------------------------------------------------------
package ialu_pkg;

    localparam int DATA_WIDTH_DEF = 64;
    localparam int FUNC_W         = 4;
    localparam int PORT_W         = 64;
    localparam int QUEUE_DEPTH    = 4;

    typedef enum logic [FUNC_W-1:0] {
        OP_ADD  = 4'd0,
        OP_SUB  = 4'd1,
        OP_MUL  = 4'd2,
        OP_REM  = 4'd3,
        OP_FDIV = 4'd4,
        OP_AND  = 4'd5,
        OP_OR   = 4'd6,
        OP_XOR  = 4'd7,
        OP_SHL  = 4'd8,
        OP_SHR  = 4'd9,
        OP_NOT  = 4'd10,
        OP_NEG  = 4'd11
    } op_t;

    // Operation class chosen by the front end
    typedef enum logic [1:0] {
        CLS_LOGIC = 2'd0,
        CLS_MUL   = 2'd1,
        CLS_DIV   = 2'd2
    } cls_t;

endpackage

// ----- hw/rtl/ialu_front.sv -----
// ----------------------------------------------------------------------------
// ialu_front
// Classify each command and compute the combinational results (add, sub, logic, shifts, not, neg).
// ----------------------------------------------------------------------------
module ialu_front
    import ialu_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
)
(
    input  logic [FUNC_W-1:0]     func,
    input  logic [DATA_WIDTH-1:0] a,
    input  logic [DATA_WIDTH-1:0] b,
    output cls_t                  cls,
    output logic [DATA_WIDTH-1:0] quick
);

    localparam int CW = $clog2(DATA_WIDTH);

    logic                  b_neg;
    logic [DATA_WIDTH-1:0] mag;
    logic                  long_sh;
    logic [CW-1:0]         amt;
    logic [DATA_WIDTH-1:0] shl_v;
    logic [DATA_WIDTH-1:0] shr_v;
    logic                  do_left;

    // Work out shift magnitude and direction
    always_comb
    begin
        b_neg   = b[DATA_WIDTH-1];
        mag     = b_neg ? (~b + 1'b1) : b;
        long_sh = (mag >= DATA_WIDTH'(DATA_WIDTH)) || (b_neg && mag[DATA_WIDTH-1]);
        amt     = mag[CW-1:0];
        shl_v   = long_sh ? '0 : (a << amt);
        shr_v   = long_sh ? {DATA_WIDTH{a[DATA_WIDTH-1]}}
                          : DATA_WIDTH'($signed(a) >>> amt);
        do_left = (func == OP_SHL) ^ b_neg;
    end

    // Decode operation
    always_comb
    begin
        cls   = CLS_LOGIC;
        quick = '0;
        case (func)
            OP_ADD:  quick = a + b;
            OP_SUB:  quick = a - b;
            OP_MUL:  cls = CLS_MUL;
            OP_REM:  cls = CLS_DIV;
            OP_FDIV: cls = CLS_DIV;
            OP_AND:  quick = a & b;
            OP_OR:   quick = a | b;
            OP_XOR:  quick = a ^ b;
            OP_SHL:  quick = do_left ? shl_v : shr_v;
            OP_SHR:  quick = do_left ? shl_v : shr_v;
            OP_NOT:  quick = ~a;
            OP_NEG:  quick = ~a + 1'b1;
            default: quick = '0;
        endcase
    end

endmodule

// ----- hw/rtl/ialu_back.sv -----
// ----------------------------------------------------------------------------
// ialu_back
// Execute one queued item: pass a front-end result through, three-step multiply
// by half-width partial products, or a radix-2 signed divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ialu_back
    import ialu_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  go,
    input  cls_t                  cls,
    input  logic                  is_rem,
    input  logic [DATA_WIDTH-1:0] a,
    input  logic [DATA_WIDTH-1:0] b,
    input  logic [DATA_WIDTH-1:0] quick,
    output logic                  idle,
    output logic                  done,
    output logic [DATA_WIDTH-1:0] res,
    output logic                  dz
);

    localparam int W  = DATA_WIDTH;
    localparam int H  = (W + 1) / 2;
    localparam int CW = $clog2(W + 1);

    typedef enum logic [2:0] { S_IDLE, S_MUL1, S_MUL2, S_MUL3, S_DIV, S_FIN } st_t;

    st_t             st_reg, st_next;
    logic [CW-1:0]   cnt_reg, cnt_next;
    logic [W-1:0]    q_reg, q_next;
    logic [W-1:0]    r_reg, r_next;
    logic [W-1:0]    d_reg, d_next;
    logic [W-1:0]    a_reg, a_next;
    logic [W-1:0]    b_reg, b_next;
    logic [W-1:0]    p_reg, p_next;
    logic            sa_reg, sa_next, sb_reg, sb_next, rem_reg, rem_next;
    logic [W:0]      trial;
    logic [W-1:0]    r_sh;
    logic [W-1:0]    qf, rf;
    logic [H-1:0]    mul_x, mul_y;
    logic [2*H-1:0]  pp;

    // Hold state and datapath
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= S_IDLE;
        end
        else
        begin
            st_reg <= st_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg <= cnt_next;
        q_reg   <= q_next;
        r_reg   <= r_next;
        d_reg   <= d_next;
        a_reg   <= a_next;
        b_reg   <= b_next;
        p_reg   <= p_next;
        sa_reg  <= sa_next;
        sb_reg  <= sb_next;
        rem_reg <= rem_next;
    end

    // Sequence the item
    always_comb
    begin
        st_next  = st_reg;
        cnt_next = cnt_reg;
        q_next   = q_reg;
        r_next   = r_reg;
        d_next   = d_reg;
        a_next   = a_reg;
        b_next   = b_reg;
        p_next   = p_reg;
        sa_next  = sa_reg;
        sb_next  = sb_reg;
        rem_next = rem_reg;
        idle     = 1'b0;
        done     = 1'b0;
        res      = p_reg;
        dz       = 1'b0;
        r_sh     = {r_reg[W-2:0], q_reg[W-1]};
        trial    = {1'b0, r_sh} - {1'b0, d_reg};
        qf       = '0;
        rf       = '0;
        // Pick the half-width operands for this multiply step
        mul_x    = (st_reg == S_MUL3) ? H'(a_reg[W-1:H]) : a_reg[H-1:0];
        mul_y    = (st_reg == S_MUL2) ? H'(b_reg[W-1:H]) : b_reg[H-1:0];
        pp       = mul_x * mul_y;
        case (st_reg)
            S_IDLE:
            begin
                idle = 1'b1;
                if (go)
                begin
                    a_next   = a;
                    b_next   = b;
                    rem_next = is_rem;
                    sa_next  = a[W-1];
                    sb_next  = b[W-1];
                    case (cls)
                        CLS_MUL:
                        begin
                            p_next  = '0;
                            st_next = S_MUL1;
                        end
                        CLS_DIV:
                        begin
                            q_next   = a[W-1] ? (~a + 1'b1) : a;
                            d_next   = b[W-1] ? (~b + 1'b1) : b;
                            r_next   = '0;
                            cnt_next = CW'(W);
                            st_next  = S_DIV;
                        end
                        default:
                        begin
                            p_next  = quick;
                            st_next = S_FIN;
                        end
                    endcase
                end
            end
            S_MUL1:
            begin
                // Low half of a times low half of b
                p_next  = pp[W-1:0];
                st_next = S_MUL2;
            end
            S_MUL2:
            begin
                // Add low a times high b, shifted
                p_next  = p_reg + (pp[W-1:0] << H);
                st_next = S_MUL3;
            end
            S_MUL3:
            begin
                // Add high a times low b, shifted
                p_next  = p_reg + (pp[W-1:0] << H);
                st_next = S_FIN;
            end
            S_DIV:
            begin
                if (d_reg == '0)
                begin
                    done    = 1'b1;
                    res     = '0;
                    dz      = 1'b1;
                    st_next = S_IDLE;
                end
                else
                begin
                    // One restoring step
                    q_next = {q_reg[W-2:0], ~trial[W]};
                    r_next = trial[W] ? r_sh : trial[W-1:0];
                    cnt_next = cnt_reg - 1'b1;
                    if (cnt_reg == CW'(1))
                    begin
                        st_next = S_FIN;
                    end
                end
                if (cnt_reg == '0)
                begin
                    st_next = S_FIN;
                end
            end
            S_FIN:
            begin
                done    = 1'b1;
                st_next = S_IDLE;
                qf = q_reg;
                rf = r_reg;
                if (cnt_reg == '0 && d_reg != '0)
                begin
                    if (rem_reg)
                    begin
                        res = sa_reg ? (~rf + 1'b1) : rf;
                    end
                    else if (sa_reg != sb_reg)
                    begin
                        res = ~(qf + (rf != '0 ? W'(1) : W'(0))) + 1'b1;
                    end
                    else
                    begin
                        res = qf;
                    end
                end
                if (cnt_reg == '0)
                begin
                    cnt_next = CW'(W);
                end
            end
            default:
            begin
                st_next = S_IDLE;
            end
        endcase
        // Non-divide paths leave cnt nonzero so FIN picks p_reg
        if (st_reg == S_IDLE && go && cls != CLS_DIV)
        begin
            cnt_next = CW'(W);
        end
    end

endmodule

// ----- hw/rtl/int64_alu_floor_div_shift.sv -----
// ----------------------------------------------------------------------------
// int64_alu_floor_div_shift
// Signed integer ALU: front decode, command queue, sequenced back end.
// ----------------------------------------------------------------------------
// Path: logic/add/shift pass idle and finish, a zero divisor ends in divide,
// multiply adds MUL1-MUL3, rem/floordiv one quotient bit per cycle in divide.
// Throughput: the 4-entry queue accepts one command per cycle unless busy;
// the back end takes the next item once idle. busy rises while queue is full.
// Reset: rst_n asynchronous active low empties queue and idles the back end.
// The receiver cannot stall: each result shows for one cycle under done.
// ----------------------------------------------------------------------------
module int64_alu_floor_div_shift
    import ialu_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic [FUNC_W-1:0]    func,
    input  logic [PORT_W-1:0]    operand_a,
    input  logic [PORT_W-1:0]    operand_b,
    output logic                 done,
    output logic [PORT_W-1:0]    result,
    output logic                 div_by_zero
);

    localparam int QW = $clog2(QUEUE_DEPTH);

    logic [DATA_WIDTH-1:0] a_in, b_in, quick;
    cls_t                  cls;

    cls_t                  q_cls   [QUEUE_DEPTH];
    logic                  q_rem   [QUEUE_DEPTH];
    logic [DATA_WIDTH-1:0] q_a     [QUEUE_DEPTH];
    logic [DATA_WIDTH-1:0] q_b     [QUEUE_DEPTH];
    logic [DATA_WIDTH-1:0] q_quick [QUEUE_DEPTH];
    logic [QW-1:0]         wp_reg, rp_reg;
    logic [QW:0]           cnt_reg;

    logic                  push, pop, be_idle, be_done, be_dz;
    logic [DATA_WIDTH-1:0] be_res;

    assign a_in = operand_a[DATA_WIDTH-1:0];
    assign b_in = operand_b[DATA_WIDTH-1:0];
    assign busy = (cnt_reg == (QW+1)'(QUEUE_DEPTH));
    assign push = start && !busy;
    assign pop  = be_idle && (cnt_reg != '0);

    ialu_front #(.DATA_WIDTH(DATA_WIDTH)) u_front (
        .func  (func),
        .a     (a_in),
        .b     (b_in),
        .cls   (cls),
        .quick (quick)
    );

    // Store classified commands
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_cls[wp_reg]   <= cls;
            q_rem[wp_reg]   <= (func == OP_REM);
            q_a[wp_reg]     <= a_in;
            q_b[wp_reg]     <= b_in;
            q_quick[wp_reg] <= quick;
        end
    end

    // Advance queue pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wp_reg <= wp_reg + 1'b1;
            end
            if (pop)
            begin
                rp_reg <= rp_reg + 1'b1;
            end
            cnt_reg <= cnt_reg + (QW+1)'(push) - (QW+1)'(pop);
        end
    end

    ialu_back #(.DATA_WIDTH(DATA_WIDTH)) u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .go     (pop),
        .cls    (q_cls[rp_reg]),
        .is_rem (q_rem[rp_reg]),
        .a      (q_a[rp_reg]),
        .b      (q_b[rp_reg]),
        .quick  (q_quick[rp_reg]),
        .idle   (be_idle),
        .done   (be_done),
        .res    (be_res),
        .dz     (be_dz)
    );

    // Sign-extend result to the port
    assign done        = be_done;
    assign result      = PORT_W'($signed(be_res));
    assign div_by_zero = be_dz;

endmodule
